// ----- hw/rtl/smup_pkg.sv -----
// shared types and constants for the serial mouse uart port
package smup_pkg;

	localparam logic [3:0] RX_OFFSET  = 4'd0;
	localparam logic [3:0] TX_OFFSET  = 4'd0;
	localparam logic [3:0] IER_OFFSET = 4'd1;
	localparam logic [3:0] IIR_OFFSET = 4'd2;
	localparam logic [3:0] LSR_OFFSET = 4'd5;

	localparam int REG_COUNT = 16;

	localparam logic [7:0] HDR_BASE  = 8'h40;
	localparam logic [7:0] HDR_NEG_X = 8'h03;
	localparam logic [7:0] HDR_NEG_Y = 8'h0c;
	localparam logic [7:0] IIR_RX    = 8'h01;
	localparam logic [7:0] IIR_TX    = 8'h04;
	localparam logic [7:0] LSR_TX    = 8'h01;
	localparam logic [7:0] LSR_RX    = 8'h00;

	localparam logic [7:0] EDGE_RESET    = 8'd50;
	localparam logic [9:0] X_LIMIT_RESET = 10'd639;
	localparam logic [9:0] Y_LIMIT_RESET = 10'd199;

	localparam logic [1:0] CFG_EDGE_OFFSET = 2'd0;
	localparam logic [1:0] CFG_X_LIMIT     = 2'd1;
	localparam logic [1:0] CFG_Y_LIMIT     = 2'd2;

	localparam logic [2:0] REQ_READ   = 3'd0;
	localparam logic [2:0] REQ_WRITE  = 3'd1;
	localparam logic [2:0] REQ_MOTION = 3'd2;
	localparam logic [2:0] REQ_BUTTON = 3'd3;
	localparam logic [2:0] REQ_TICK   = 3'd4;

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		OP_READ   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_MOTION = 3'd2,
		OP_BUTTON = 3'd3,
		OP_TICK   = 3'd4,
		OP_NONE   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		PH_X    = 3'b001,
		PH_Y    = 3'b010,
		PH_IDLE = 3'b100
	} phase_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] addr;
		logic [7:0] wdata;
		logic       neg_x;
		logic       neg_y;
		logic [5:0] dx6;
		logic [5:0] dy6;
		logic [9:0] pos_x;
		logic [9:0] pos_y;
		logic       right;
		logic       down;
		logic       pend;
	} cmd_t;

endpackage

// ----- hw/rtl/smup_front.sv -----
// front end: config registers, request decode and pointer clamping
module smup_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [2:0]        req_type,
	input  logic [3:0]        reg_addr,
	input  logic [7:0]        write_data,
	input  logic signed [10:0] delta_x,
	input  logic signed [10:0] delta_y,
	input  logic [11:0]       abs_x,
	input  logic [11:0]       abs_y,
	input  logic              button_right,
	input  logic              button_down,
	input  logic              irq_pending,
	input  logic              full,
	output logic              push,
	output smup_pkg::cmd_t    cmd
);
	import smup_pkg::*;

	logic [7:0]        edge_q;
	logic [9:0]        xlim_q;
	logic [9:0]        ylim_q;
	logic signed [12:0] tx;
	logic signed [12:0] ty;
	logic [10:0]       ty_half;
	logic [9:0]        px;
	logic [9:0]        py;
	op_t               op;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= EDGE_RESET;
			xlim_q <= X_LIMIT_RESET;
			ylim_q <= Y_LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_EDGE_OFFSET: edge_q <= cfg_data[7:0];
				CFG_X_LIMIT:     xlim_q <= cfg_data;
				CFG_Y_LIMIT:     ylim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tx      = $signed({1'b0, abs_x}) - $signed({5'b0, edge_q});
	assign ty      = $signed({1'b0, abs_y}) - $signed({5'b0, edge_q});
	assign ty_half = ty[11:1];

	always_comb begin
		if (tx[12])
			px = '0;
		else if (tx[11:0] > {2'b0, xlim_q})
			px = xlim_q;
		else
			px = tx[9:0];
		if (ty[12])
			py = '0;
		else if (ty_half > {1'b0, ylim_q})
			py = ylim_q;
		else
			py = ty_half[9:0];
	end

	always_comb begin
		unique case (req_type)
			REQ_READ:   op = OP_READ;
			REQ_WRITE:  op = OP_WRITE;
			REQ_MOTION: op = OP_MOTION;
			REQ_BUTTON: op = OP_BUTTON;
			REQ_TICK:   op = OP_TICK;
			default:    op = OP_NONE;
		endcase
	end

	assign req_ready = !full;
	assign push      = req_valid && !full;

	always_comb begin
		cmd.op    = op;
		cmd.addr  = reg_addr;
		cmd.wdata = write_data;
		cmd.neg_x = delta_x[10];
		cmd.neg_y = delta_y[10];
		cmd.dx6   = delta_x[5:0];
		cmd.dy6   = delta_y[5:0];
		cmd.pos_x = px;
		cmd.pos_y = py;
		cmd.right = button_right;
		cmd.down  = button_down;
		cmd.pend  = irq_pending;
	end

endmodule

// ----- hw/rtl/smup_fifo.sv -----
// short command queue between front and back
module smup_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smup_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output smup_pkg::cmd_t rd_cmd
);
	import smup_pkg::*;

	cmd_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full   = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- hw/rtl/smup_back.sv -----
// back end: register file, packet sender, pointer state and result register
module smup_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  smup_pkg::cmd_t cmd,
	output logic           pop,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output logic [7:0]     read_data,
	output logic           irq_raise,
	output logic [9:0]     pointer_x,
	output logic [9:0]     pointer_y,
	output logic [1:0]     button_bits
);
	import smup_pkg::*;

	typedef logic [REG_COUNT-1:0][7:0] rf_t;

	typedef struct packed {
		rf_t  rf;
		logic raised;
	} wr_res_t;

	function automatic wr_res_t bus_wr(input rf_t rf, input logic [3:0] a, input logic [7:0] b);
		wr_res_t r;
		r.rf     = rf;
		r.raised = 1'b0;
		r.rf[a]  = b;
		if (a == TX_OFFSET) begin
			r.rf[LSR_OFFSET] = LSR_TX;
			if (r.rf[IER_OFFSET][0]) begin
				r.rf[IIR_OFFSET] = IIR_TX;
				r.raised         = 1'b1;
			end
		end
		return r;
	endfunction

	rf_t        rf_q;
	rf_t        rf_n;
	phase_t     ph_q;
	phase_t     ph_n;
	logic [5:0] xb_q;
	logic [5:0] yb_q;
	logic [5:0] xb_n;
	logic [5:0] yb_n;
	logic [9:0] px_q;
	logic [9:0] py_q;
	logic [9:0] px_n;
	logic [9:0] py_n;
	logic [1:0] btn_q;
	logic [1:0] btn_n;
	logic [1:0] bit_sel;
	logic [7:0] rd;
	logic [7:0] hdr;
	logic       raise;
	logic       pend;
	wr_res_t    wr;
	logic       rsp_valid_q;
	logic [7:0] rdata_q;
	logic       raise_q;

	assign pop = !empty && (!rsp_valid_q || rsp_ready);

	always_comb begin
		rf_n    = rf_q;
		ph_n    = ph_q;
		xb_n    = xb_q;
		yb_n    = yb_q;
		px_n    = px_q;
		py_n    = py_q;
		btn_n   = btn_q;
		rd      = '0;
		raise   = 1'b0;
		pend    = cmd.pend;
		wr      = '0;
		bit_sel = cmd.right ? 2'b01 : 2'b10;
		hdr     = HDR_BASE | (cmd.neg_x ? HDR_NEG_X : '0) | (cmd.neg_y ? HDR_NEG_Y : '0);
		unique case (cmd.op)
			OP_READ: begin
				if (cmd.addr == RX_OFFSET) begin
					rf_n[IIR_OFFSET] = IIR_RX;
					rf_n[LSR_OFFSET] = LSR_RX;
				end
				rd = rf_n[cmd.addr];
			end
			OP_WRITE: begin
				wr    = bus_wr(rf_n, cmd.addr, cmd.wdata);
				rf_n  = wr.rf;
				raise = wr.raised;
			end
			OP_MOTION: begin
				if (ph_q == PH_IDLE) begin
					xb_n  = cmd.dx6;
					yb_n  = cmd.dy6;
					ph_n  = PH_X;
					wr    = bus_wr(rf_n, TX_OFFSET, hdr);
					rf_n  = wr.rf;
					raise = wr.raised;
				end
				px_n = cmd.pos_x;
				py_n = cmd.pos_y;
			end
			OP_BUTTON: begin
				if (cmd.down)
					btn_n = btn_q | bit_sel;
				else
					btn_n = btn_q & ~bit_sel;
			end
			OP_TICK: begin
				if (ph_n == PH_X && !pend) begin
					ph_n = PH_Y;
					wr   = bus_wr(rf_n, TX_OFFSET, {2'b00, xb_q});
					rf_n = wr.rf;
					if (wr.raised) begin
						raise = 1'b1;
						pend  = 1'b1;
					end
				end
				if (ph_n == PH_Y && !pend) begin
					ph_n = PH_IDLE;
					wr   = bus_wr(rf_n, TX_OFFSET, {2'b00, yb_q});
					rf_n = wr.rf;
					if (wr.raised)
						raise = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q        <= '0;
			ph_q        <= PH_IDLE;
			xb_q        <= '0;
			yb_q        <= '0;
			px_q        <= '0;
			py_q        <= '0;
			btn_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rf_q  <= rf_n;
				ph_q  <= ph_n;
				xb_q  <= xb_n;
				yb_q  <= yb_n;
				px_q  <= px_n;
				py_q  <= py_n;
				btn_q <= btn_n;
			end
			if (pop)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rdata_q <= rd;
			raise_q <= raise;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign read_data   = rdata_q;
	assign irq_raise   = raise_q;
	assign pointer_x   = px_q;
	assign pointer_y   = py_q;
	assign button_bits = btn_q;

endmodule

// ----- hw/rtl/serial_mouse_uart_port_core.sv -----
// top level of the serial mouse uart port
// One request is taken per clock while the queue has room; each gives exactly one
// response, registered as its request leaves the queue. A two-entry queue separates request
// decode from execution, so a stalled response side still absorbs two more requests; the
// back end sets the rate and updates the sixteen-byte register file, the packet sender
// and pointer state once per cycle in which it pops. Reset clears all but queue and
// response data at once; config writes are taken on any cycle and act on later requests.
module serial_mouse_uart_port_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [9:0]        cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [2:0]        req_type,
	input  logic [3:0]        reg_addr,
	input  logic [7:0]        write_data,
	input  logic signed [10:0] delta_x,
	input  logic signed [10:0] delta_y,
	input  logic [11:0]       abs_x,
	input  logic [11:0]       abs_y,
	input  logic              button_right,
	input  logic              button_down,
	input  logic              irq_pending,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [7:0]        read_data,
	output logic              irq_raise,
	output logic [9:0]        pointer_x,
	output logic [9:0]        pointer_y,
	output logic [1:0]        button_bits
);
	import smup_pkg::*;

	cmd_t front_cmd;
	cmd_t back_cmd;
	logic push;
	logic full;
	logic pop;
	logic empty;

	smup_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req_type     (req_type),
		.reg_addr     (reg_addr),
		.write_data   (write_data),
		.delta_x      (delta_x),
		.delta_y      (delta_y),
		.abs_x        (abs_x),
		.abs_y        (abs_y),
		.button_right (button_right),
		.button_down  (button_down),
		.irq_pending  (irq_pending),
		.full         (full),
		.push         (push),
		.cmd          (front_cmd)
	);

	smup_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.rd_cmd (back_cmd)
	);

	smup_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.cmd         (back_cmd),
		.pop         (pop),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.read_data   (read_data),
		.irq_raise   (irq_raise),
		.pointer_x   (pointer_x),
		.pointer_y   (pointer_y),
		.button_bits (button_bits)
	);

endmodule

// ----- hw/rtl/smup_checker.sv -----
// port-level checks for the serial mouse uart port, bound to the top level
module smup_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [7:0]        read_data,
	input logic              irq_raise,
	input logic [9:0]        pointer_x,
	input logic [9:0]        pointer_y,
	input logic [1:0]        button_bits
);

	logic [2:0] outstanding_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if (req_fire && !rsp_fire)
			outstanding_q <= outstanding_q + 1'b1;
		else if (!req_fire && rsp_fire)
			outstanding_q <= outstanding_q - 1'b1;
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(irq_raise)
			&& $stable(pointer_x) && $stable(pointer_y) && $stable(button_bits))
		else $error("response changed while stalled");

	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && irq_raise |-> read_data == 8'd0)
		else $error("interrupt raised on a response carrying read data");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> outstanding_q != 3'd0)
		else $error("response without a request");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |-> outstanding_q < 3'd3)
		else $error("request taken beyond queue capacity");

endmodule

bind serial_mouse_uart_port_core smup_checker u_smup_checker (.*);
